// File: rtl/obn_pkg.sv
// shared widths, defaults and the side record of the orthonormal basis pipeline
// used by obn_ratio_pipe and orthonormal_basis_from_normal; no dependencies
`default_nettype none

package obn_pkg;

   localparam int DIR_W         = 16;  // one vector component
   localparam int SQ_W          = 32;  // square of a component, sum of two squares
   localparam int PROD_W        = 32;  // component times tangent component
   localparam int FRAC_BITS_DEF = 14;

   typedef struct packed {
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
      logic                    sel;    // |x| > |y|: tangent lies in the x-z plane
      logic                    degen;  // selected squared sum is zero
   } side_type;

endpackage

`default_nettype wire

// File: rtl/orthonormal_basis_from_normal.sv
// throughput: one word per cycle while rsp_tready does not hold the output stage;
// the FRAC_BITS+1 stage bitwise ratio search sets the depth
// an input skid register keeps req_tready registered; a stall holds every stage in place
// reset clears the stage valid bits and the skid register; no data store needs clearing
// top level of the orthonormal basis pipeline; depends on obn_pkg and obn_ratio_pipe
`default_nettype none

module orthonormal_basis_from_normal
   import obn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,   // dir_x, dir_y, dir_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,   // tangent_x/y/z, bitangent_x/y/z
   output logic [0:0]        rsp_tuser    // degenerate
);

   localparam int ACC_W   = 2*FRAC_BITS + 38;
   localparam int K_W     = FRAC_BITS + 1;
   localparam int M_W     = (K_W > DIR_W+1) ? K_W : DIR_W+1;
   localparam int RND_W   = PROD_W + 2;
   localparam int N_STG   = FRAC_BITS + 7;
   localparam int ONE_VAL = 1 << FRAC_BITS;
   localparam int POS_LIM = (ONE_VAL < 32767) ? ONE_VAL : 32767;
   localparam int NEG_MAG = (ONE_VAL < 32768) ? ONE_VAL : 32768;

   localparam logic [M_W-1:0]          T_POS = M_W'(POS_LIM);
   localparam logic [M_W-1:0]          T_NEG = M_W'(NEG_MAG);
   localparam logic signed [RND_W-1:0] B_POS = RND_W'(POS_LIM);
   localparam logic signed [RND_W-1:0] B_NEG = RND_W'(-NEG_MAG);
   localparam logic signed [RND_W-1:0] HALF  = RND_W'(1) << (FRAC_BITS-1);

   // sign * k, clamped to the range of one and of the field
   function automatic logic [DIR_W-1:0] tan_comp(input logic [K_W-1:0] k, input logic neg);
      logic [M_W-1:0] mag;
      logic [M_W-1:0] val;
      mag = M_W'(k);
      if (neg) begin
         if (mag > T_NEG) mag = T_NEG;
         val = -mag;
      end else begin
         if (mag > T_POS) mag = T_POS;
         val = mag;
      end
      return val[DIR_W-1:0];
   endfunction

   // (p - q + half) >>> FRAC_BITS, clamped
   function automatic logic [DIR_W-1:0] bit_comp(input logic signed [PROD_W-1:0] p,
                                                 input logic signed [PROD_W-1:0] q);
      logic signed [RND_W-1:0] w;
      logic signed [RND_W-1:0] r;
      w = RND_W'(p) - RND_W'(q) + HALF;
      r = w >>> FRAC_BITS;
      if (r > B_POS) r = B_POS;
      if (r < B_NEG) r = B_NEG;
      return r[DIR_W-1:0];
   endfunction

   logic                 adv;
   logic [N_STG-1:0]     vld_ff;
   logic [N_STG-1:0]     vld_in;

   // input skid
   logic                 skid_vld_ff;
   logic                 skid_vld_in;
   logic [47:0]          skid_data_ff;
   logic                 head_vld;
   logic [47:0]          head_data;

   // front stages
   side_type             head_side;
   logic [DIR_W-1:0]     abs_x;
   logic [DIR_W-1:0]     abs_y;
   side_type             s1_ff;
   side_type             s2_ff;
   logic signed [DIR_W-1:0] sel_a;
   logic signed [PROD_W-1:0] sq_a_full;
   logic signed [PROD_W-1:0] sq_z_full;
   logic [SQ_W-1:0]      sq_a_ff;
   logic [SQ_W-1:0]      sq_z_ff;
   logic [SQ_W-1:0]      sum_in;
   side_type             s3_ff;
   side_type             s3_in;
   logic [SQ_W-1:0]      sum_ff;
   logic [SQ_W-1:0]      sq_a3_ff;
   logic [SQ_W-1:0]      sq_z3_ff;
   logic signed [ACC_W-1:0] rhs_p;
   logic signed [ACC_W-1:0] rhs_q;

   // search stages
   side_type             line_ff [0:FRAC_BITS];
   logic [K_W-1:0]       k_p;
   logic [K_W-1:0]       k_q;

   // tangent, products, output
   side_type             tail;
   logic                 neg_p;
   logic                 neg_q;
   logic [DIR_W-1:0]     t_p;
   logic [DIR_W-1:0]     t_q;
   logic signed [DIR_W-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [DIR_W-1:0] tx_in, ty_in, tz_in;
   side_type             tt_ff;
   logic signed [DIR_W-1:0] px_ff, py_ff, pz_ff;
   logic                 pdeg_ff;
   logic signed [PROD_W-1:0] m_dy_tz_ff, m_dz_ty_ff, m_dz_tx_ff;
   logic signed [PROD_W-1:0] m_dx_tz_ff, m_dx_ty_ff, m_dy_tx_ff;
   logic [95:0]          out_data_ff;
   logic [95:0]          out_data_in;
   logic                 out_deg_ff;

   assign adv        = !vld_ff[N_STG-1] || rsp_tready;
   assign req_tready = !skid_vld_ff;

   assign head_vld  = skid_vld_ff || req_tvalid;
   assign head_data = skid_vld_ff ? skid_data_ff : req_tdata;

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (adv) begin
         skid_vld_in = 1'b0;
      end else if (req_tvalid && req_tready) begin
         skid_vld_in = 1'b1;
      end
   end

   assign vld_in = {vld_ff[N_STG-2:0], head_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_tvalid && req_tready) begin
         skid_data_ff <= req_tdata;
      end
   end

   // stage 1: capture word, pick the component pair
   assign abs_x = head_data[15] ? -head_data[15:0] : head_data[15:0];
   assign abs_y = head_data[31] ? -head_data[31:16] : head_data[31:16];

   always_comb begin
      head_side.dx    = $signed(head_data[15:0]);
      head_side.dy    = $signed(head_data[31:16]);
      head_side.dz    = $signed(head_data[47:32]);
      head_side.sel   = abs_x > abs_y;
      head_side.degen = 1'b0;
   end

   // stage 2: squares; the pair's squares are also the lanes' magnitudes squared
   assign sel_a     = s1_ff.sel ? s1_ff.dx : s1_ff.dy;
   assign sq_a_full = PROD_W'(sel_a) * PROD_W'(sel_a);
   assign sq_z_full = PROD_W'(s1_ff.dz) * PROD_W'(s1_ff.dz);

   // stage 3: squared sum and degenerate flag
   assign sum_in = sq_a_ff + sq_z_ff;

   always_comb begin
      s3_in       = s2_ff;
      s3_in.degen = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= head_side;
         s2_ff    <= s1_ff;
         sq_a_ff  <= $unsigned(sq_a_full);
         sq_z_ff  <= $unsigned(sq_z_full);
         s3_ff    <= s3_in;
         sum_ff   <= sum_in;
         sq_a3_ff <= sq_a_ff;
         sq_z3_ff <= sq_z_ff;
      end
   end

   // lane p carries the z-derived component, lane q the x or y one
   assign rhs_p = $signed({{(ACC_W-SQ_W){1'b0}}, sq_z3_ff}) <<< (2*FRAC_BITS+2);
   assign rhs_q = $signed({{(ACC_W-SQ_W){1'b0}}, sq_a3_ff}) <<< (2*FRAC_BITS+2);

   obn_ratio_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ratio_p (
      .clock (clock),
      .en    (adv),
      .s_sum (sum_ff),
      .rhs   (rhs_p),
      .k_out (k_p)
   );

   obn_ratio_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ratio_q (
      .clock (clock),
      .en    (adv),
      .s_sum (sum_ff),
      .rhs   (rhs_q),
      .k_out (k_q)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= s3_ff;
         for (int i = 1; i <= FRAC_BITS; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   // tangent stage
   assign tail  = line_ff[FRAC_BITS];
   assign neg_p = tail.sel ? (!tail.dz[DIR_W-1] && (tail.dz != '0)) : tail.dz[DIR_W-1];
   assign neg_q = tail.sel ? tail.dx[DIR_W-1] : (!tail.dy[DIR_W-1] && (tail.dy != '0));
   assign t_p   = tan_comp(k_p, neg_p);
   assign t_q   = tan_comp(k_q, neg_q);

   always_comb begin
      tx_in = '0;
      ty_in = '0;
      tz_in = '0;
      if (!tail.degen) begin
         tz_in = $signed(t_q);
         if (tail.sel) begin
            tx_in = $signed(t_p);
         end else begin
            ty_in = $signed(t_p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tz_ff <= tz_in;
         tt_ff <= tail;
      end
   end

   // product stage for the cross product
   always_ff @(posedge clock) begin
      if (adv) begin
         m_dy_tz_ff <= PROD_W'(tt_ff.dy) * PROD_W'(tz_ff);
         m_dz_ty_ff <= PROD_W'(tt_ff.dz) * PROD_W'(ty_ff);
         m_dz_tx_ff <= PROD_W'(tt_ff.dz) * PROD_W'(tx_ff);
         m_dx_tz_ff <= PROD_W'(tt_ff.dx) * PROD_W'(tz_ff);
         m_dx_ty_ff <= PROD_W'(tt_ff.dx) * PROD_W'(ty_ff);
         m_dy_tx_ff <= PROD_W'(tt_ff.dy) * PROD_W'(tx_ff);
         px_ff      <= tx_ff;
         py_ff      <= ty_ff;
         pz_ff      <= tz_ff;
         pdeg_ff    <= tt_ff.degen;
      end
   end

   // output stage: round, clamp, pack
   always_comb begin
      out_data_in[15:0]  = px_ff;
      out_data_in[31:16] = py_ff;
      out_data_in[47:32] = pz_ff;
      out_data_in[63:48] = bit_comp(m_dy_tz_ff, m_dz_ty_ff);
      out_data_in[79:64] = bit_comp(m_dz_tx_ff, m_dx_tz_ff);
      out_data_in[95:80] = bit_comp(m_dx_ty_ff, m_dy_tx_ff);
      if (pdeg_ff) begin
         out_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
         out_deg_ff  <= pdeg_ff;
      end
   end

   assign rsp_tvalid   = vld_ff[N_STG-1];
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_deg_ff;

   // degenerate words carry zero vectors
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate word with nonzero vectors");

   // a usable pair always yields a nonzero tangent
   a_tangent_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:0] != '0)
      else $error("zero tangent on a non-degenerate word");

   // tangent x and z components stay within plus or minus one
   a_tangent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= POS_LIM)
                  && ($signed(rsp_tdata[15:0]) >= -NEG_MAG)
                  && ($signed(rsp_tdata[47:32]) <= POS_LIM)
                  && ($signed(rsp_tdata[47:32]) >= -NEG_MAG))
      else $error("tangent component out of range");

   // the skid only fills while the pipeline is held
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> !$past(adv))
      else $error("skid loaded while pipeline advanced");

endmodule

`default_nettype wire

// File: rtl/obn_ratio_pipe.sv
// pipelined search for k = round(mag * 2^FRAC_BITS / sqrt(s)), one bit of k per stage
// takes s and rhs = 4 * mag^2 * 2^(2*FRAC_BITS); depends on obn_pkg
`default_nettype none

module obn_ratio_pipe
   import obn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [SQ_W-1:0]                 s_sum,
   input  wire logic signed [2*FRAC_BITS+37:0]  rhs,
   output logic [FRAC_BITS:0]                   k_out
);

   localparam int ACC_W = 2*FRAC_BITS + 38;
   localparam int K_W   = FRAC_BITS + 1;

   // a = (2k-1)^2 * s and b = (2k-1) * s for the k found so far
   logic signed [ACC_W-1:0] a_ff [0:FRAC_BITS-1];
   logic signed [ACC_W-1:0] b_ff [0:FRAC_BITS-1];
   logic signed [ACC_W-1:0] r_ff [0:FRAC_BITS-1];
   logic [SQ_W-1:0]         s_ff [0:FRAC_BITS-1];
   logic [K_W-1:0]          k_ff [0:FRAC_BITS];

   for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_step
      localparam int BIT = FRAC_BITS - j;
      logic signed [ACC_W-1:0] a_prev;
      logic signed [ACC_W-1:0] b_prev;
      logic signed [ACC_W-1:0] r_prev;
      logic signed [ACC_W-1:0] s_ext;
      logic signed [ACC_W-1:0] a_try;
      logic [SQ_W-1:0]         s_prev;
      logic [K_W-1:0]          k_prev;
      logic [K_W-1:0]          k_in;
      logic                    take;

      if (j == 0) begin : g_first
         assign s_prev = s_sum;
         assign a_prev = s_ext;
         assign b_prev = -s_ext;
         assign r_prev = rhs;
         assign k_prev = '0;
      end else begin : g_next
         assign s_prev = s_ff[j-1];
         assign a_prev = a_ff[j-1];
         assign b_prev = b_ff[j-1];
         assign r_prev = r_ff[j-1];
         assign k_prev = k_ff[j-1];
      end

      assign s_ext = $signed({{(ACC_W-SQ_W){1'b0}}, s_prev});

      // (odd + 2^(BIT+1))^2 * s from the running terms, shifts only
      assign a_try = a_prev + (b_prev <<< (BIT+2)) + (s_ext <<< (2*BIT+2));
      // once k reaches one, every larger candidate is out of range
      assign take  = !k_prev[FRAC_BITS] && (a_try <= r_prev);
      assign k_in  = take ? (k_prev | (K_W'(1) << BIT)) : k_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            k_ff[j] <= k_in;
         end
      end

      if (j < FRAC_BITS) begin : g_carry
         logic signed [ACC_W-1:0] a_in;
         logic signed [ACC_W-1:0] b_in;

         assign a_in = take ? a_try : a_prev;
         assign b_in = take ? (b_prev + (s_ext <<< (BIT+1))) : b_prev;

         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[j] <= a_in;
               b_ff[j] <= b_in;
               r_ff[j] <= r_prev;
               s_ff[j] <= s_prev;
            end
         end
      end
   end

   assign k_out = k_ff[FRAC_BITS];

endmodule

`default_nettype wire
